/* design/wtp_pkg.sv */
package wtp_pkg;

  // Defaults for the top level parameters
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int WEIGHT_BITS_DEF   = 16;

  // Fixed field widths
  localparam int INDEX_BITS       = 4;
  localparam int LOAD_WEIGHT_BITS = 16;
  localparam int CODE_BITS        = 4;
  localparam int NOISE_BITS       = 32;
  localparam int COUNT_BITS       = 5;

  // APB register map: one 32-bit register per word
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_SHIFT     = 2;
  localparam logic [APB_ADDR_BITS-REG_SHIFT-1:0] REG_ENTRY_COUNT = '0;

  // Item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PICK = 1'b1;

  // Default bands, used when no entries are in use
  localparam int BAND_MOD = 100;
  localparam int BAND_LO  = 10;
  localparam int BAND_MID = 40;
  localparam int BAND_HI  = 70;
  localparam logic [CODE_BITS-1:0] BAND_CODE_LO  = 4'd3;
  localparam logic [CODE_BITS-1:0] BAND_CODE_MID = 4'd1;
  localparam logic [CODE_BITS-1:0] BAND_CODE_HI  = 4'd2;
  localparam logic [CODE_BITS-1:0] BAND_CODE_TOP = 4'd0;
  localparam logic [CODE_BITS-1:0] FALLBACK_MASK = 4'h3;

  // noise / 100 == (noise * BAND_RECIP) >> BAND_SHIFT for every 32-bit noise
  localparam logic [NOISE_BITS-1:0] BAND_RECIP = 32'h51EB_851F;
  localparam int                    BAND_SHIFT = 37;

  // Microprogram addresses
  typedef logic [3:0] pc_t;
  localparam pc_t P_WAIT    = 4'd0;
  localparam pc_t P_CHECK   = 4'd1;
  localparam pc_t P_SUM0    = 4'd2;
  localparam pc_t P_SUM     = 4'd3;
  localparam pc_t P_TOTAL   = 4'd4;
  localparam pc_t P_DIV     = 4'd5;
  localparam pc_t P_SCAN0   = 4'd6;
  localparam pc_t P_SCAN    = 4'd7;
  localparam pc_t P_BQUOT   = 4'd8;
  localparam pc_t P_BREM    = 4'd9;
  localparam pc_t P_BAND    = 4'd10;
  localparam pc_t P_EMIT    = 4'd11;

  typedef enum logic [3:0] {
    OP_WAIT, OP_NONE, OP_SUM0, OP_SUM, OP_TOTAL, OP_DIV,
    OP_SCAN0, OP_SCAN, OP_BQUOT, OP_BREM, OP_BAND, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_PICK, C_EMPTY, C_LAST, C_DIVEND, C_SCANEND, C_OUTFREE
  } cond_t;

  // Jump to target when cond holds, else stay (hold) or fall through
  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    pc_t   target;
  } uword_t;

  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      P_WAIT:    w = '{OP_WAIT,   C_PICK,    1'b1, P_CHECK};
      P_CHECK:   w = '{OP_NONE,   C_EMPTY,   1'b0, P_BQUOT};
      P_SUM0:    w = '{OP_SUM0,   C_ALWAYS,  1'b0, P_SUM};
      P_SUM:     w = '{OP_SUM,    C_LAST,    1'b1, P_TOTAL};
      P_TOTAL:   w = '{OP_TOTAL,  C_ALWAYS,  1'b0, P_DIV};
      P_DIV:     w = '{OP_DIV,    C_DIVEND,  1'b1, P_SCAN0};
      P_SCAN0:   w = '{OP_SCAN0,  C_ALWAYS,  1'b0, P_SCAN};
      P_SCAN:    w = '{OP_SCAN,   C_SCANEND, 1'b1, P_EMIT};
      P_BQUOT:   w = '{OP_BQUOT,  C_ALWAYS,  1'b0, P_BREM};
      P_BREM:    w = '{OP_BREM,   C_ALWAYS,  1'b0, P_BAND};
      P_BAND:    w = '{OP_BAND,   C_ALWAYS,  1'b0, P_EMIT};
      P_EMIT:    w = '{OP_EMIT,   C_OUTFREE, 1'b1, P_WAIT};
      default:   w = '{OP_WAIT,   C_PICK,    1'b1, P_CHECK};
    endcase
    return w;
  endfunction

endpackage

/* design/wtp_if.sv */
interface wtp_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic [wtp_pkg::INDEX_BITS-1:0]        entry_index;
  logic [wtp_pkg::LOAD_WEIGHT_BITS-1:0]  entry_weight;
  logic [wtp_pkg::CODE_BITS-1:0]         entry_terrain;
  logic [wtp_pkg::NOISE_BITS-1:0]        noise;

  modport source (output valid, action, entry_index, entry_weight, entry_terrain, noise,
                  input ready);
  modport sink   (input valid, action, entry_index, entry_weight, entry_terrain, noise,
                  output ready);
endinterface

interface wtp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [wtp_pkg::CODE_BITS-1:0] terrain;

  modport source (output valid, terrain, input ready);
  modport sink   (input valid, terrain, output ready);
endinterface

/* design/wtp_ram.sv */
module wtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/weighted_terrain_pick_top.sv */
// Weighted terrain pick. A load item (action 0) writes one (weight, terrain) pair
// into the table; slots at or beyond TABLE_ENTRIES are dropped. A pick item
// (action 1) returns one terrain code. With entry_count zero the code comes from
// four fixed bands of noise mod 100: noise mod 100 comes from a reciprocal multiply,
// then a 7-bit back-subtraction, then the band compare. Otherwise the block sums
// the first n weights (n = entry_count, saturated to TABLE_ENTRIES), reduces noise
// mod that sum (mod n if the sum is zero), then scans the running sum for the first
// entry above the remainder; if none is found the result is noise AND 3. That path
// uses the 32-step restoring divider (one noise bit per cycle) and the table RAM's
// single read port, which gives one entry per cycle to the sum and the scan.
// Control is a twelve-step microprogram in a ROM; one control word per step selects the
// datapath operation, a jump condition and a target. The table resets to zero through
// one valid bit per entry, so no clearing pass is needed. A result waits in an output
// register; the next item is taken as soon as the sequencer is back at its wait step.
// No item is taken while rst is high.
// entry_count is written through APB at byte address 0 and may only change while idle.
module weighted_terrain_pick_top #(
  parameter int TABLE_ENTRIES = wtp_pkg::TABLE_ENTRIES_DEF,
  parameter int WEIGHT_BITS   = wtp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  wtp_req_if.sink                            req,
  wtp_rsp_if.source                          rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wtp_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [wtp_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [wtp_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import wtp_pkg::*;

  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int SUM_RAW = WEIGHT_BITS + CNT_W;            // never wraps
  localparam int MOD_W   = $clog2(BAND_MOD + 1);
  localparam int SUM_W   = (SUM_RAW > MOD_W) ? SUM_RAW : MOD_W;
  localparam int ENTRY_W = WEIGHT_BITS + CODE_BITS;
  localparam int BIT_W   = $clog2(NOISE_BITS);
  localparam int PROD_W  = 2 * NOISE_BITS;

  // ---------------- configuration port ----------------
  logic [COUNT_BITS-1:0]                  entry_count;
  logic [APB_ADDR_BITS-REG_SHIFT-1:0]     reg_idx;
  logic                                   cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_BITS-1:REG_SHIFT];
  assign cfg_we  = psel && penable && pwrite && pready && (reg_idx == REG_ENTRY_COUNT);
  assign prdata  = (reg_idx == REG_ENTRY_COUNT) ? APB_DATA_BITS'(entry_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= pwdata[COUNT_BITS-1:0];
    end
  end

  // ---------------- sequencer ----------------
  pc_t    pc;
  pc_t    pc_next;
  uword_t word;
  logic   cond_ok;

  // datapath registers
  logic [CNT_W-1:0]      n_reg;
  logic [CNT_W-1:0]      k;          // table index being read
  logic [NOISE_BITS-1:0] noise_reg;
  logic [SUM_W-1:0]      acc;        // weight sum, then running sum during the scan
  logic [SUM_W-1:0]      total;      // divisor
  logic [SUM_W-1:0]      rem;        // partial remainder
  logic [BIT_W-1:0]      dcnt;       // divider step
  logic [MOD_W-1:0]      band_qlo;   // low bits of noise / 100
  logic [CODE_BITS-1:0]  pick_code;
  logic                  rsp_valid;
  logic [CODE_BITS-1:0]  rsp_terrain;

  // table storage
  logic [TABLE_ENTRIES-1:0] live;    // entry written since reset
  logic                     rd_live;
  logic [ENTRY_W-1:0]       rdata;
  logic                     load_we;
  logic [IDX_W-1:0]         waddr;
  logic [ENTRY_W-1:0]       wdata;

  // datapath signals
  logic                  req_fire;
  logic                  pick_fire;
  logic [CNT_W-1:0]      n_sat;
  logic [WEIGHT_BITS-1:0] d_weight;
  logic [CODE_BITS-1:0]  d_code;
  logic [SUM_W-1:0]      acc_sum;
  logic                  hit;
  logic                  last;
  logic                  noise_bit;
  logic [SUM_W:0]        shifted;
  logic [SUM_W-1:0]      rem_step;
  logic                  div_end;
  logic                  out_free;
  logic [PROD_W-1:0]     band_prod;
  logic [MOD_W-1:0]      band_rem;
  logic [CODE_BITS-1:0]  band_code;

  assign word = ucode(pc);

  assign req.ready = !rst && (word.op == OP_WAIT);
  assign req_fire  = req.valid && req.ready;
  assign pick_fire = req_fire && (req.action == ACT_PICK);

  // entry_count above the table depth acts as a full table
  assign n_sat = (32'(entry_count) > 32'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES)
                                                         : CNT_W'(entry_count);

  // loads
  assign load_we = req_fire && (req.action == ACT_LOAD) &&
                   (32'(req.entry_index) < 32'(TABLE_ENTRIES));
  assign waddr   = IDX_W'(req.entry_index);
  assign wdata   = {WEIGHT_BITS'(req.entry_weight), req.entry_terrain};

  wtp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (k[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (load_we) begin
      live[waddr] <= 1'b1;
    end
  end

  // valid bit follows the registered read; unwritten entries read as zero
  always_ff @(posedge clk) begin
    rd_live <= (k < CNT_W'(TABLE_ENTRIES)) && live[k[IDX_W-1:0]];
  end

  assign d_weight = rd_live ? rdata[ENTRY_W-1:CODE_BITS] : '0;
  assign d_code   = rd_live ? rdata[CODE_BITS-1:0] : '0;
  assign acc_sum  = acc + SUM_W'(d_weight);
  assign hit      = rem < acc_sum;
  assign last     = (k == n_reg);

  // restoring divider, MSB of noise first
  assign noise_bit = noise_reg[BIT_W'(NOISE_BITS - 1) - dcnt];
  assign shifted   = {rem, noise_bit};
  assign rem_step  = (shifted >= {1'b0, total}) ? SUM_W'(shifted - {1'b0, total})
                                                : shifted[SUM_W-1:0];
  assign div_end   = (dcnt == BIT_W'(NOISE_BITS - 1));

  // noise mod 100: quotient by reciprocal multiply, then the remainder is below 128,
  // so only the low bits of noise and of quotient * 100 are needed
  assign band_prod = PROD_W'(noise_reg) * PROD_W'(BAND_RECIP);
  assign band_rem  = noise_reg[MOD_W-1:0] - MOD_W'(band_qlo * MOD_W'(BAND_MOD));

  assign out_free = !rsp_valid || rsp.ready;

  always_comb begin
    if (rem < SUM_W'(BAND_LO)) begin
      band_code = BAND_CODE_LO;
    end else if (rem < SUM_W'(BAND_MID)) begin
      band_code = BAND_CODE_MID;
    end else if (rem < SUM_W'(BAND_HI)) begin
      band_code = BAND_CODE_HI;
    end else begin
      band_code = BAND_CODE_TOP;
    end
  end

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:  cond_ok = 1'b1;
      C_PICK:    cond_ok = pick_fire;
      C_EMPTY:   cond_ok = (n_reg == '0);
      C_LAST:    cond_ok = last;
      C_DIVEND:  cond_ok = div_end;
      C_SCANEND: cond_ok = hit || last;
      C_OUTFREE: cond_ok = out_free;
      default:   cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_ok) begin
      pc_next = word.target;
    end else if (word.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // datapath, driven by the control word
  always_ff @(posedge clk) begin
    case (word.op)
      OP_WAIT: begin
        if (pick_fire) begin
          noise_reg <= req.noise;
          n_reg     <= n_sat;
          k         <= '0;
        end
      end
      OP_SUM0: begin
        acc <= '0;
        k   <= CNT_W'(1);
      end
      OP_SUM: begin
        acc <= acc_sum;
        if (!last) begin
          k <= k + CNT_W'(1);
        end
      end
      OP_TOTAL: begin
        // all weights zero: reduce mod the entry count
        total <= (acc == '0) ? SUM_W'(n_reg) : acc;
        rem   <= '0;
        dcnt  <= '0;
        k     <= '0;
      end
      OP_BQUOT: begin
        band_qlo <= band_prod[BAND_SHIFT +: MOD_W];
      end
      OP_BREM: begin
        rem <= SUM_W'(band_rem);
      end
      OP_DIV: begin
        rem  <= rem_step;
        dcnt <= dcnt + BIT_W'(1);
      end
      OP_SCAN0: begin
        acc <= '0;
        k   <= CNT_W'(1);
      end
      OP_SCAN: begin
        acc <= acc_sum;
        if (hit) begin
          pick_code <= d_code;
        end else if (last) begin
          pick_code <= noise_reg[CODE_BITS-1:0] & FALLBACK_MASK;
        end else begin
          k <= k + CNT_W'(1);
        end
      end
      OP_BAND: begin
        pick_code <= band_code;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((word.op == OP_EMIT) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((word.op == OP_EMIT) && out_free) begin
      rsp_terrain <= pick_code;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.terrain = rsp_terrain;

  // ---------------- assertions ----------------
  a_pick_starts: assert property (@(posedge clk) disable iff (rst)
    pick_fire |=> (pc == P_CHECK))
    else $error("pick item did not start the program");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (pc == P_DIV) |-> (rem < total))
    else $error("divider remainder not below divisor");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    ((pc == P_SUM) || (pc == P_SCAN)) |-> ((k <= n_reg) && (k != '0)))
    else $error("table index outside the entries in use");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    ((pc == P_EMIT) && rsp_valid && !rsp.ready) |=> (pc == P_EMIT))
    else $error("result emitted over a stalled one");

endmodule
